>>> hdl/assert_macros.svh
// Assertion macros for the collapse block's RTL.
// No dependencies; empty bodies when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// clocked check, masked while reset is high
`define PMTC_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("pmtc assertion failed");

// clocked check, live during reset as well
`define PMTC_ASSERT_ALWAYS(lbl, clk, prop) \
   lbl: assert property (@(posedge clk) prop) \
      else $error("pmtc assertion failed");

`else

`define PMTC_ASSERT(lbl, clk, rst, prop)
`define PMTC_ASSERT_ALWAYS(lbl, clk, prop)

`endif

`endif

>>> hdl/pmtc_pkg.sv
// Shared types, constants and helpers for the triangle collapse block.
// No dependencies.
package pmtc_pkg;

   localparam int IDX_W       = 12;
   localparam int LINK_W      = 13;
   localparam int CFG_W       = 13;
   localparam int CNT_W       = 16;
   localparam int MAX_VERTS   = 4096;
   localparam int STEP_W      = $clog2(MAX_VERTS + 1);
   localparam int TABLE_DEPTH = 1 << IDX_W;
   localparam int CORNERS     = 3;
   localparam int CORNER_W    = $clog2(CORNERS);

   localparam logic [CNT_W-1:0] CNT_MAX = '1;

   typedef enum logic [0:0] {
      CSR_VERTEX_LIMIT = 1'b0,
      CSR_VERTEX_COUNT = 1'b1
   } csr_index_type;

   typedef enum logic [0:0] {
      FUNC_WRITE    = 1'b0,
      FUNC_TRIANGLE = 1'b1
   } func_type;

   typedef enum logic [1:0] {
      W_IDLE,
      W_START,
      W_WALK,
      W_DONE
   } walk_state_type;

   typedef struct packed {
      logic [CFG_W-1:0] limit;
      logic [CFG_W-1:0] count;
   } cfg_type;

   typedef struct packed {
      logic             valid;
      logic             keep;
      logic [IDX_W-1:0] a;
      logic [IDX_W-1:0] b;
      logic [IDX_W-1:0] c;
      logic             last;
   } tri_result_type;

   // true while a walk must take another link
   function automatic logic walk_ok(logic [IDX_W-1:0]  v,
                                    logic [STEP_W-1:0] steps,
                                    logic [CFG_W-1:0]  limit,
                                    logic [CFG_W-1:0]  count);
      logic [CFG_W-1:0] vx;
      vx = CFG_W'(v);
      return (vx >= limit) && (vx < count) && (steps < STEP_W'(MAX_VERTS));
   endfunction

endpackage

>>> hdl/pmtc_table_ram.sv
// Generic single-write, single-read synchronous RAM, registered read.
// No dependencies.
module pmtc_table_ram #(
   parameter int ADDR_W = 12,
   parameter int DATA_W = 13
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [DATA_W-1:0] wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [DATA_W-1:0] rd_data
);

   logic [DATA_W-1:0] mem_ff [(1 << ADDR_W)];
   logic [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> hdl/pmtc_walk_ctrl.sv
// Sequencer: loads table entries and walks the three corner chains.
// Depends on pmtc_pkg and assert_macros.svh; drives pmtc_table_ram.
`include "assert_macros.svh"

module pmtc_walk_ctrl import pmtc_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  cfg_type                  cfg,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  logic                     req_func,
   input  logic [IDX_W-1:0]         req_table_index,
   input  logic signed [LINK_W-1:0] req_table_link,
   input  logic [IDX_W-1:0]         req_vert_a,
   input  logic [IDX_W-1:0]         req_vert_b,
   input  logic [IDX_W-1:0]         req_vert_c,
   input  logic                     req_last_triangle,
   output logic                     ram_wr_en,
   output logic [IDX_W-1:0]         ram_wr_addr,
   output logic [LINK_W-1:0]        ram_wr_data,
   output logic                     ram_rd_en,
   output logic [IDX_W-1:0]         ram_rd_addr,
   input  logic [LINK_W-1:0]        ram_rd_data,
   output tri_result_type           res,
   input  logic                     res_take
);

   walk_state_type               state_ff, state_in;
   logic [CORNER_W-1:0]          corner_ff, corner_in;
   logic [CORNERS-1:0][IDX_W-1:0] v_ff, v_in;
   logic [IDX_W-1:0]             cur_ff, cur_in;
   logic [STEP_W-1:0]            steps_ff, steps_in;
   logic                         last_ff, last_in;

   logic                         fin;
   logic [IDX_W-1:0]             fin_v;
   logic [IDX_W-1:0]             start_v;
   logic [IDX_W-1:0]             next_v;
   logic [STEP_W-1:0]            next_steps;
   logic                         bypass;
   logic                         distinct;
   logic                         below;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= W_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      corner_ff <= corner_in;
      v_ff      <= v_in;
      cur_ff    <= cur_in;
      steps_ff  <= steps_in;
      last_ff   <= last_in;
   end

   assign start_v    = v_ff[corner_ff];
   assign next_v     = ram_rd_data[IDX_W-1:0];
   assign next_steps = steps_ff + STEP_W'(1);

   always_comb begin
      state_in    = state_ff;
      corner_in   = corner_ff;
      v_in        = v_ff;
      cur_in      = cur_ff;
      steps_in    = steps_ff;
      last_in     = last_ff;
      req_ready   = 1'b0;
      ram_wr_en   = 1'b0;
      ram_rd_en   = 1'b0;
      ram_rd_addr = cur_ff;
      fin         = 1'b0;
      fin_v       = cur_ff;
      unique case (state_ff)
         W_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               if (req_func == FUNC_WRITE) begin
                  ram_wr_en = 1'b1;
               end else begin
                  v_in[0]   = req_vert_a;
                  v_in[1]   = req_vert_b;
                  v_in[2]   = req_vert_c;
                  last_in   = req_last_triangle;
                  corner_in = '0;
                  steps_in  = '0;
                  state_in  = W_START;
               end
            end
         end
         W_START: begin
            if (walk_ok(start_v, steps_ff, cfg.limit, cfg.count)) begin
               ram_rd_en   = 1'b1;
               ram_rd_addr = start_v;
               cur_in      = start_v;
               state_in    = W_WALK;
            end else begin
               fin   = 1'b1;
               fin_v = start_v;
            end
         end
         W_WALK: begin
            // sign bit set or self link: cur is the root
            if (ram_rd_data[LINK_W-1] || (next_v == cur_ff)) begin
               fin   = 1'b1;
               fin_v = cur_ff;
            end else if (walk_ok(next_v, next_steps, cfg.limit, cfg.count)) begin
               ram_rd_en   = 1'b1;
               ram_rd_addr = next_v;
               cur_in      = next_v;
               steps_in    = next_steps;
            end else begin
               fin   = 1'b1;
               fin_v = next_v;
            end
         end
         W_DONE: begin
            if (res_take) begin
               state_in = W_IDLE;
            end
         end
         default: begin
            state_in = W_IDLE;
         end
      endcase

      if (fin) begin
         v_in[corner_ff] = fin_v;
         steps_in        = '0;
         if (corner_ff == CORNER_W'(CORNERS - 1)) begin
            state_in = W_DONE;
         end else begin
            corner_in = corner_ff + CORNER_W'(1);
            state_in  = W_START;
         end
      end
   end

   assign ram_wr_addr = req_table_index;
   assign ram_wr_data = LINK_W'(req_table_link);

   assign bypass   = cfg.limit >= cfg.count;
   assign distinct = (v_ff[0] != v_ff[1]) && (v_ff[1] != v_ff[2]) && (v_ff[0] != v_ff[2]);
   assign below    = (CFG_W'(v_ff[0]) < cfg.limit) && (CFG_W'(v_ff[1]) < cfg.limit) &&
                     (CFG_W'(v_ff[2]) < cfg.limit);

   always_comb begin
      res.valid = (state_ff == W_DONE);
      res.keep  = bypass || (distinct && below);
      res.a     = v_ff[0];
      res.b     = v_ff[1];
      res.c     = v_ff[2];
      res.last  = last_ff;
   end

   `PMTC_ASSERT(a_walk_has_read, clock, reset, (state_ff == W_WALK) |-> $past(ram_rd_en))
   `PMTC_ASSERT(a_ready_no_result, clock, reset, req_ready |-> !res.valid)
   `PMTC_ASSERT(a_wr_on_accept, clock, reset,
      ram_wr_en |-> (req_valid && req_ready && (req_func == FUNC_WRITE)))
   `PMTC_ASSERT(a_result_holds, clock, reset,
      (res.valid && !res_take) |=> (res.valid && $stable(res.a) && $stable(res.b) &&
         $stable(res.c) && $stable(res.keep)))
   `PMTC_ASSERT(a_steps_capped, clock, reset,
      (state_ff != W_IDLE) |-> (steps_ff <= STEP_W'(MAX_VERTS)))

endmodule

>>> hdl/progressive_mesh_triangle_collapse.sv
// Top level of the progressive-mesh triangle collapse block.
// Depends on pmtc_pkg, pmtc_table_ram and pmtc_walk_ctrl.
//
// Collapse table writes (func 0) return no beat. A triangle (func 1) holds
// the sequencer from its accept until its result beat is taken into the
// output register. The single read port of the 4096 x 13 collapse table
// RAM sets the pace: a walk reads one link per cycle and the corners are
// walked one after another. Each walk stops after MAX_VERTS links, so a
// cyclic table cannot hang the block. Results sit in an output register; a
// write beat is taken while a result waits, and a following triangle stalls
// only at its end if the previous result is still not taken. The table has
// no reset: reading an entry never written gives an undefined link. Write
// vertex_limit and vertex_count only while idle.

module progressive_mesh_triangle_collapse import pmtc_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   // request channel
   input  logic                     req_valid,
   output logic                     req_ready,
   input  logic                     req_func,
   input  logic [IDX_W-1:0]         req_table_index,
   input  logic signed [LINK_W-1:0] req_table_link,
   input  logic [IDX_W-1:0]         req_vert_a,
   input  logic [IDX_W-1:0]         req_vert_b,
   input  logic [IDX_W-1:0]         req_vert_c,
   input  logic                     req_last_triangle,
   // response channel
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic                     rsp_kept,
   output logic [IDX_W-1:0]         rsp_out_a,
   output logic [IDX_W-1:0]         rsp_out_b,
   output logic [IDX_W-1:0]         rsp_out_c,
   output logic [CNT_W-1:0]         rsp_kept_count,
   output logic                     rsp_out_last,
   // configuration writes
   input  logic                     csr_wr_en,
   input  logic [0:0]               csr_index,
   input  logic [CFG_W-1:0]         csr_wr_data
);

   cfg_type           cfg_ff, cfg_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [CNT_W-1:0]  count_next;
   logic              rsp_valid_ff, rsp_valid_in;
   logic              rsp_kept_ff;
   logic [IDX_W-1:0]  rsp_a_ff, rsp_b_ff, rsp_c_ff;
   logic [CNT_W-1:0]  rsp_count_ff;
   logic              rsp_last_ff;

   logic              ram_wr_en;
   logic [IDX_W-1:0]  ram_wr_addr;
   logic [LINK_W-1:0] ram_wr_data;
   logic              ram_rd_en;
   logic [IDX_W-1:0]  ram_rd_addr;
   logic [LINK_W-1:0] ram_rd_data;

   tri_result_type    res;
   logic              res_take;

   // ---------------- configuration registers ----------------
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         unique case (csr_index_type'(csr_index))
            CSR_VERTEX_LIMIT: cfg_in.limit = csr_wr_data;
            CSR_VERTEX_COUNT: cfg_in.count = csr_wr_data;
            default:          cfg_in       = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.limit <= CFG_W'(TABLE_DEPTH);
         cfg_ff.count <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // ---------------- collapse table and walker ----------------
   pmtc_table_ram #(
      .ADDR_W (IDX_W),
      .DATA_W (LINK_W)
   ) u_table (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   pmtc_walk_ctrl u_walk (
      .clock             (clock),
      .reset             (reset),
      .cfg               (cfg_ff),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_func          (req_func),
      .req_table_index   (req_table_index),
      .req_table_link    (req_table_link),
      .req_vert_a        (req_vert_a),
      .req_vert_b        (req_vert_b),
      .req_vert_c        (req_vert_c),
      .req_last_triangle (req_last_triangle),
      .ram_wr_en         (ram_wr_en),
      .ram_wr_addr       (ram_wr_addr),
      .ram_wr_data       (ram_wr_data),
      .ram_rd_en         (ram_rd_en),
      .ram_rd_addr       (ram_rd_addr),
      .ram_rd_data       (ram_rd_data),
      .res               (res),
      .res_take          (res_take)
   );

   // ---------------- kept counter and output register ----------------
   // the output slot frees when empty or when its beat leaves this cycle
   assign res_take = res.valid && (!rsp_valid_ff || rsp_ready);

   // saturating count, this triangle included
   assign count_next = (res.keep && (count_ff != CNT_MAX)) ? count_ff + CNT_W'(1) : count_ff;

   always_comb begin
      count_in     = count_ff;
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (res_take) begin
         rsp_valid_in = 1'b1;
         count_in     = res.last ? '0 : count_next;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (res_take) begin
         rsp_kept_ff  <= res.keep;
         rsp_a_ff     <= res.a;
         rsp_b_ff     <= res.b;
         rsp_c_ff     <= res.c;
         rsp_count_ff <= count_next;
         rsp_last_ff  <= res.last;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_kept       = rsp_kept_ff;
   assign rsp_out_a      = rsp_a_ff;
   assign rsp_out_b      = rsp_b_ff;
   assign rsp_out_c      = rsp_c_ff;
   assign rsp_kept_count = rsp_count_ff;
   assign rsp_out_last   = rsp_last_ff;

endmodule

>>> tb/testbench.sv
// Self-checking testbench for progressive_mesh_triangle_collapse: directed and random beats,
// checked against a built-in collapse predictor. Depends on pmtc_pkg and the RTL top level.
`timescale 1ns / 100ps

module testbench;
   import pmtc_pkg::*;

   localparam int HALF_PERIOD    = 5;
   localparam int RESET_CYCLES   = 10;
   localparam int SETTLE_CYCLES  = 16;     // lets a trailing write beat finish
   localparam int WATCHDOG_LIMIT = 40000;  // must outlast the longest walk, a cyclic one
   localparam int PHASES         = 12;
   localparam int TRIS_PER_PHASE = 120;
   localparam int CHAIN_SPAN     = 48;     // chain entries loaded per phase, at most
   localparam int MAX_REPORTS    = 10;

   // one request beat, all fields
   typedef struct {
      func_type                 func;
      logic [IDX_W-1:0]         index;
      logic signed [LINK_W-1:0] link;
      logic [IDX_W-1:0]         a;
      logic [IDX_W-1:0]         b;
      logic [IDX_W-1:0]         c;
      logic                     last;
   } collapse_req_type;

   // one remapped triangle as the response channel shows it
   typedef struct packed {
      logic             kept;
      logic [IDX_W-1:0] a;
      logic [IDX_W-1:0] b;
      logic [IDX_W-1:0] c;
      logic [CNT_W-1:0] count;
      logic             last;
   } remap_type;

   // ---------------------------------------------------------------------
   // DUT ports, the inputs all known from time zero
   // ---------------------------------------------------------------------
   logic                     clock             = 1'b0;
   logic                     reset             = 1'b1;
   logic                     req_valid         = 1'b0;
   logic                     req_ready;
   logic                     req_func          = FUNC_WRITE;
   logic [IDX_W-1:0]         req_table_index   = '0;
   logic signed [LINK_W-1:0] req_table_link    = '0;
   logic [IDX_W-1:0]         req_vert_a        = '0;
   logic [IDX_W-1:0]         req_vert_b        = '0;
   logic [IDX_W-1:0]         req_vert_c        = '0;
   logic                     req_last_triangle = 1'b0;
   logic                     rsp_valid;
   logic                     rsp_ready         = 1'b0;
   logic                     rsp_kept;
   logic [IDX_W-1:0]         rsp_out_a;
   logic [IDX_W-1:0]         rsp_out_b;
   logic [IDX_W-1:0]         rsp_out_c;
   logic [CNT_W-1:0]         rsp_kept_count;
   logic                     rsp_out_last;
   logic                     csr_wr_en         = 1'b0;
   logic [0:0]               csr_index         = CSR_VERTEX_LIMIT;
   logic [CFG_W-1:0]         csr_wr_data       = '0;

   progressive_mesh_triangle_collapse DUT (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_func          (req_func),
      .req_table_index   (req_table_index),
      .req_table_link    (req_table_link),
      .req_vert_a        (req_vert_a),
      .req_vert_b        (req_vert_b),
      .req_vert_c        (req_vert_c),
      .req_last_triangle (req_last_triangle),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_kept          (rsp_kept),
      .rsp_out_a         (rsp_out_a),
      .rsp_out_b         (rsp_out_b),
      .rsp_out_c         (rsp_out_c),
      .rsp_kept_count    (rsp_kept_count),
      .rsp_out_last      (rsp_out_last),
      .csr_wr_en         (csr_wr_en),
      .csr_index         (csr_index),
      .csr_wr_data       (csr_wr_data)
   );

   always #HALF_PERIOD clock = ~clock;

   // ---------------------------------------------------------------------
   // Predictor state: mirror of the registers, the table and the counter
   // ---------------------------------------------------------------------
   logic [CFG_W-1:0]         lod_limit    = CFG_W'(4096);
   logic [CFG_W-1:0]         lod_count    = '0;
   logic [CNT_W-1:0]         surface_kept = '0;
   logic signed [LINK_W-1:0] link_mem     [TABLE_DEPTH];
   bit                       link_written [TABLE_DEPTH];
   remap_type                remap_q      [$];   // triangles still owed by the DUT

   int req_idle_pct  = 0;
   int rsp_stall_pct = 0;
   int error_count   = 0;
   int quiet_cycles  = 0;
   int tri_beats     = 0;
   int kept_beats    = 0;
   int write_beats   = 0;
   int csr_writes    = 0;
   int rsp_beats     = 0;

   // Follow one corner down its collapse chain. Stops at a root (negative or
   // self link), once outside [limit, count), or after MAX_VERTS links.
   // blind is set when the walk would read an entry never loaded; such a
   // corner is never sent.
   function automatic logic [IDX_W-1:0] collapse_walk(input  logic [IDX_W-1:0] start,
                                                       output bit               blind);
      logic [CFG_W-1:0]         v;
      logic signed [LINK_W-1:0] nxt;
      int                       steps;
      bit                       stop;
      v     = CFG_W'(start);
      steps = 0;
      stop  = 0;
      blind = 0;
      while (!stop && v >= lod_limit && v < lod_count && steps < MAX_VERTS) begin
         if (!link_written[v[IDX_W-1:0]]) begin
            blind = 1;
            stop  = 1;
         end else begin
            nxt = link_mem[v[IDX_W-1:0]];
            if (nxt < 0 || nxt[IDX_W-1:0] == v[IDX_W-1:0]) begin
               stop = 1;
            end else begin
               v = CFG_W'(nxt[IDX_W-1:0]);
               steps++;
            end
         end
      end
      return v[IDX_W-1:0];
   endfunction

   // Update the mirror for one accepted beat; triangles queue their result.
   function automatic void apply_beat(input collapse_req_type it);
      remap_type r;
      bit        blind;
      if (it.func == FUNC_WRITE) begin
         link_mem[it.index]     = it.link;
         link_written[it.index] = 1;
         write_beats++;
      end else begin
         r.a    = it.a;
         r.b    = it.b;
         r.c    = it.c;
         r.last = it.last;
         if (lod_limit >= lod_count) begin
            r.kept = 1'b1;   // nothing collapses: pass through, even degenerate
         end else begin
            r.a    = collapse_walk(it.a, blind);
            r.b    = collapse_walk(it.b, blind);
            r.c    = collapse_walk(it.c, blind);
            r.kept = (r.a != r.b) && (r.b != r.c) && (r.a != r.c) &&
                     CFG_W'(r.a) < lod_limit && CFG_W'(r.b) < lod_limit &&
                     CFG_W'(r.c) < lod_limit;
         end
         if (r.kept && surface_kept != CNT_MAX)
            surface_kept++;
         r.count = surface_kept;
         if (it.last)
            surface_kept = '0;
         remap_q = {remap_q, r};
         tri_beats++;
         if (r.kept)
            kept_beats++;
      end
   endfunction

   // ---------------------------------------------------------------------
   // Request side: drive at the falling edge, hold until the beat is taken
   // ---------------------------------------------------------------------
   task automatic send_item(input collapse_req_type it);
      @(negedge clock);
      while ($urandom_range(99) < req_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid         <= 1'b1;
      req_func          <= it.func;
      req_table_index   <= it.index;
      req_table_link    <= it.link;
      req_vert_a        <= it.a;
      req_vert_b        <= it.b;
      req_vert_c        <= it.c;
      req_last_triangle <= it.last;
      @(posedge clock);
      while (!req_ready)
         @(posedge clock);
      apply_beat(it);
   endtask

   task automatic send_write(input logic [IDX_W-1:0] idx, input logic signed [LINK_W-1:0] lnk,
                             input logic last);
      collapse_req_type it;
      it.func  = FUNC_WRITE;
      it.index = idx;
      it.link  = lnk;
      it.a     = IDX_W'($urandom());   // ignored on a write beat
      it.b     = IDX_W'($urandom());
      it.c     = IDX_W'($urandom());
      it.last  = last;
      send_item(it);
   endtask

   task automatic send_tri(input logic [IDX_W-1:0] a, input logic [IDX_W-1:0] b,
                           input logic [IDX_W-1:0] c, input logic last);
      collapse_req_type it;
      it.func  = FUNC_TRIANGLE;
      it.index = IDX_W'($urandom());   // ignored on a triangle beat
      it.link  = LINK_W'($urandom());
      it.a     = a;
      it.b     = b;
      it.c     = c;
      it.last  = last;
      send_item(it);
   endtask

   // Block goes idle: no valid, nothing owed, and a trailing write beat done.
   task automatic settle();
      @(negedge clock);
      req_valid <= 1'b0;
      while (remap_q.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(input csr_index_type idx, input logic [CFG_W-1:0] val);
      @(negedge clock);
      csr_wr_en   <= 1'b1;
      csr_index   <= idx;
      csr_wr_data <= val;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      case (idx)
         CSR_VERTEX_LIMIT: lod_limit = val;
         CSR_VERTEX_COUNT: lod_count = val;
      endcase
      csr_writes++;
   endtask

   task automatic set_levels(input logic [CFG_W-1:0] limit, input logic [CFG_W-1:0] count);
      settle();
      write_csr(CSR_VERTEX_LIMIT, limit);
      write_csr(CSR_VERTEX_COUNT, count);
   endtask

   task automatic set_idle(input int mode);
      case (mode)
         0:       begin req_idle_pct = 0;  rsp_stall_pct = 0;  end
         1:       begin req_idle_pct = 66; rsp_stall_pct = 0;  end
         2:       begin req_idle_pct = 0;  rsp_stall_pct = 66; end
         default: begin req_idle_pct = 15; rsp_stall_pct = 15; end
      endcase
   endtask

   // ---------------------------------------------------------------------
   // Response side: random backpressure, in-order check of every beat
   // ---------------------------------------------------------------------
   always @(negedge clock)
      rsp_ready <= ($urandom_range(99) >= rsp_stall_pct);

   always @(posedge clock) begin : check_results
      remap_type want;
      remap_type seen;
      if (!reset && rsp_valid && rsp_ready) begin
         rsp_beats++;
         seen = '{rsp_kept, rsp_out_a, rsp_out_b, rsp_out_c, rsp_kept_count, rsp_out_last};
         if (remap_q.size() == 0) begin
            error_count++;
            if (error_count <= MAX_REPORTS)
               $display("%0t: result beat with no triangle pending: kept=%0d a=%0d b=%0d c=%0d",
                        $realtime, seen.kept, seen.a, seen.b, seen.c);
         end else begin
            want = remap_q.pop_front();
            if (seen.kept !== want.kept || seen.a !== want.a || seen.b !== want.b ||
                seen.c !== want.c || seen.count !== want.count || seen.last !== want.last) begin
               error_count++;
               if (error_count <= MAX_REPORTS) begin
                  $display("%0t: mismatch, expected kept=%0d a=%0d b=%0d c=%0d count=%0d last=%0d",
                           $realtime, want.kept, want.a, want.b, want.c, want.count, want.last);
                  $display("           got      kept=%0d a=%0d b=%0d c=%0d count=%0d last=%0d",
                           seen.kept, seen.a, seen.b, seen.c, seen.count, seen.last);
               end
            end
         end
      end
   end

   // A hung handshake ends the run.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("%0t: no beat for %0d cycles", $realtime, WATCHDOG_LIMIT);
         $display("** progressive_mesh_triangle_collapse: FAILED **");
         $finish;
      end
   end

   // ---------------------------------------------------------------------
   // Stimulus helpers for the random phases
   // ---------------------------------------------------------------------

   // Mostly downward links so chains run several links deep and stay
   // acyclic; the rest are roots or jumps past the vertex count.
   function automatic logic signed [LINK_W-1:0] chain_link(input int v);
      int r;
      r = $urandom_range(99);
      if (r < 70)
         return LINK_W'(v - int'($urandom_range(1, 3)));   // below zero gives a root
      else if (r < 80)
         return LINK_W'(v);
      else if (r < 90)
         return LINK_W'(-int'($urandom_range(1, 4096)));
      else if (lod_count < CFG_W'(TABLE_DEPTH))
         return LINK_W'($urandom_range(lod_count, TABLE_DEPTH - 1));
      else
         return LINK_W'(v);
   endfunction

   // Corner whose walk reads only loaded entries; prefers the busy window.
   function automatic logic [IDX_W-1:0] pick_corner(input int lo, input int hi);
      logic [IDX_W-1:0] cand;
      bit               blind;
      int               base;
      for (int n = 0; n < 24; n++) begin
         if (n < 12 && $urandom_range(99) >= 20)
            cand = IDX_W'($urandom_range(lo, hi));
         else
            cand = IDX_W'($urandom());
         void'(collapse_walk(cand, blind));
         if (!blind)
            return cand;
      end
      base = $urandom_range(TABLE_DEPTH - 1);
      for (int n = 0; n < TABLE_DEPTH; n++) begin
         cand = IDX_W'(base + n);
         void'(collapse_walk(cand, blind));
         if (!blind)
            return cand;
      end
      return cand;   // unreachable: in every phase some corner walks without a blind read
   endfunction

   // ---------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------

   // Reset levels: limit 4096 is not below count 0, so every triangle comes
   // back as sent and kept, degenerate ones too.
   task automatic test_pass_through();
      send_tri(12'd0,    12'd0,    12'd0,    1'b0);
      send_tri(12'hFFF,  12'hFFF,  12'hFFF,  1'b0);
      send_tri(12'h555,  12'hAAA,  12'hFFF,  1'b1);
   endtask

   // Limit 8, count 16: a three-link chain, a shared target, roots by
   // negative and by self link, and a corner past the vertex count.
   task automatic test_chain_walks();
      set_levels(13'd8, 13'd16);
      send_write(12'd15, 13'sd14, 1'b1);   // last flag ignored on writes
      send_write(12'd14, 13'sd9,  1'b0);
      send_write(12'd9,  13'sd2,  1'b0);
      send_write(12'd13, -13'sd4096, 1'b0);
      send_write(12'd12, 13'sd12, 1'b0);
      send_write(12'd10, 13'sd4,  1'b0);
      send_write(12'd11, 13'sd4,  1'b0);
      send_tri(12'd15, 12'd10, 12'd1,  1'b0);   // kept as 2,4,1
      send_tri(12'd10, 12'd11, 12'd5,  1'b0);   // both land on 4
      send_tri(12'd13, 12'd1,  12'd2,  1'b0);   // negative root above limit
      send_tri(12'd12, 12'd3,  12'd4,  1'b0);   // self root above limit
      send_tri(12'd1,  12'd2,  12'd20, 1'b0);   // 20 is past the count
      send_tri(12'd0,  12'd1,  12'd2,  1'b1);
   endtask

   // 14 <-> 15 loop: walks stop after the step cap.
   task automatic test_cyclic_table();
      send_write(12'd14, 13'sd15, 1'b0);
      send_write(12'd9,  13'sd15, 1'b0);
      send_tri(12'd9, 12'd14, 12'd3, 1'b1);
   endtask

   // Register extremes, including values above 4096 and limit equal to count.
   task automatic test_register_extremes();
      set_levels(13'd0, 13'd4096);
      send_write(12'hFFF, -13'sd1, 1'b0);
      send_tri(12'hFFF, 12'd12, 12'd13, 1'b0);   // every vertex lies in the collapse window
      set_levels(13'd4096, 13'd8191);
      send_tri(12'd1, 12'd1, 12'd2, 1'b0);
      send_tri(12'hFFF, 12'd0, 12'd2048, 1'b1);
      set_levels(13'd8191, 13'd0);
      send_tri(12'd7, 12'd7, 12'd7, 1'b0);
      set_levels(13'd16, 13'd16);
      send_tri(12'd15, 12'd14, 12'd1, 1'b1);
   endtask

   // Each phase: new levels, a chain table over the collapsing window, then
   // triangles around it with a sprinkle of stray table writes. Idling
   // cycles through none, sender, receiver and both.
   task automatic test_random_phases();
      int               limit;
      int               count;
      int               wend;
      int               lo;
      int               hi;
      int               r;
      logic [IDX_W-1:0] a;
      logic [IDX_W-1:0] b;
      logic [IDX_W-1:0] c;
      logic [IDX_W-1:0] idx;
      logic signed [LINK_W-1:0] lnk;
      for (int p = 0; p < PHASES; p++) begin
         set_idle(p % 4);
         case (p)
            0: begin limit = $urandom_range(4, 24); count = limit + $urandom_range(8, 40); end
            1: begin limit = 0; count = $urandom_range(16, 48); end
            2: begin count = $urandom_range(0, 4096); limit = $urandom_range(count, 8191); end
            3: begin count = 4096; limit = 4096 - $urandom_range(16, 48); end
            4: begin count = 4096; limit = 0; end
            5: begin limit = $urandom_range(1, 200); count = limit + $urandom_range(1, 48); end
            6: begin count = $urandom_range(4097, 8191); limit = $urandom_range(2000, 4095); end
            7: begin count = $urandom_range(1, 4096); limit = count - 1; end
            default: begin
               limit = $urandom_range(0, 64);
               count = limit + $urandom_range(1, 48);
            end
         endcase
         set_levels(CFG_W'(limit), CFG_W'(count));

         wend = count;
         if (wend > TABLE_DEPTH)
            wend = TABLE_DEPTH;
         if (wend > limit + CHAIN_SPAN)
            wend = limit + CHAIN_SPAN;
         for (int v = limit; v < wend; v++)
            send_write(IDX_W'(v), chain_link(v), 1'($urandom_range(1)));

         if (limit >= count) begin
            lo = 0;
            hi = TABLE_DEPTH - 1;
         end else begin
            lo = (limit > 6) ? limit - 6 : 0;
            hi = (wend + 3 > TABLE_DEPTH - 1) ? TABLE_DEPTH - 1 : wend + 3;
         end

         for (int t = 0; t < TRIS_PER_PHASE; t++) begin
            if ($urandom_range(99) < 6) begin
               // stray write; upward links become self so no loop forms
               idx = IDX_W'($urandom());
               lnk = LINK_W'($urandom_range(0, 8191));
               if (!lnk[LINK_W-1] && lnk[IDX_W-1:0] > idx)
                  lnk = LINK_W'(idx);
               send_write(idx, lnk, 1'($urandom_range(1)));
            end
            a = pick_corner(lo, hi);
            b = pick_corner(lo, hi);
            c = pick_corner(lo, hi);
            r = $urandom_range(99);
            if (r < 6)
               b = a;
            else if (r < 10)
               c = b;
            send_tri(a, b, c, $urandom_range(99) < 8);
         end
      end
   endtask

   // ---------------------------------------------------------------------
   // Main sequence
   // ---------------------------------------------------------------------
   initial begin
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_pass_through();
      test_chain_walks();
      test_cyclic_table();
      test_register_extremes();
      test_random_phases();

      settle();
      if (remap_q.size() != 0) begin
         error_count += remap_q.size();
         $display("%0d triangle results never arrived", remap_q.size());
      end

      $display("Sent %0d triangles (%0d kept) and %0d table writes under %0d register writes;",
               tri_beats, kept_beats, write_beats, csr_writes);
      $display("checked %0d result beats, %0d failures.", rsp_beats, error_count);
      if (error_count == 0)
         $display("** progressive_mesh_triangle_collapse: PASSED **");
      else
         $display("** progressive_mesh_triangle_collapse: FAILED **");
      $finish;
   end

endmodule

>>> sim.f
+incdir+hdl
hdl/pmtc_pkg.sv
hdl/pmtc_table_ram.sv
hdl/pmtc_walk_ctrl.sv
hdl/progressive_mesh_triangle_collapse.sv
tb/testbench.sv
